/* design/tlam_pkg.sv */
// Shared types, codes and reset defaults for the tank level alarm monitor.
`default_nettype none

package tlam_pkg;

  localparam int COUNT_BITS_DEF = 8;
  localparam int TIMER_BITS_DEF = 16;

  // Config port
  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;
  localparam int REG_IDX_BITS = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_WINDOW    = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_INTERVAL  = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_REP_ACKED = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_REP_UNACK = 3'd4;

  localparam logic [7:0]  WINDOW_RST    = 8'd100;
  localparam logic [7:0]  THRESHOLD_RST = 8'd75;
  localparam logic [15:0] INTERVAL_RST  = 16'd120;   // 2 minutes
  localparam logic [15:0] REP_ACKED_RST = 16'd3600;  // 1 hour
  localparam logic [15:0] REP_UNACK_RST = 16'd600;   // 10 minutes

  // Item kinds
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_RADIO  = 2'd2;

  // Levels
  localparam logic [1:0] LVL_LOW  = 2'd0;
  localparam logic [1:0] LVL_GOOD = 2'd1;
  localparam logic [1:0] LVL_HIGH = 2'd2;

  // Display pulse codes
  localparam logic [1:0] SHOW_NONE = 2'd0;
  localparam logic [1:0] SHOW_LOW  = 2'd1;
  localparam logic [1:0] SHOW_GOOD = 2'd2;
  localparam logic [1:0] SHOW_HIGH = 2'd3;

  // Report request codes
  localparam logic [1:0] REP_NONE = 2'd0;
  localparam logic [1:0] REP_LOW  = 2'd1;
  localparam logic [1:0] REP_HIGH = 2'd2;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_RADIO = 2'd1,
    PH_WAIT  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  window_length;
    logic [7:0]  vote_threshold;
    logic [15:0] check_interval;
    logic [15:0] repeat_acked;
    logic [15:0] repeat_unacked;
  } cfg_t;

  typedef struct packed {
    logic [1:0] report_request;
    logic [1:0] show_level;
    logic       want_samples;
    logic       link_error;
    logic [1:0] current_level;
  } result_t;

endpackage

`default_nettype wire

/* design/tlam_cfg.sv */
// APB-style configuration register file.
`default_nettype none

module tlam_cfg
  import tlam_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  cfg_t                    cfg_r;
  logic                    wr_en;
  logic [REG_IDX_BITS-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[ADDR_BITS-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_length  <= WINDOW_RST;
      cfg_r.vote_threshold <= THRESHOLD_RST;
      cfg_r.check_interval <= INTERVAL_RST;
      cfg_r.repeat_acked   <= REP_ACKED_RST;
      cfg_r.repeat_unacked <= REP_UNACK_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WINDOW:    cfg_r.window_length  <= pwdata[7:0];
        REG_THRESHOLD: cfg_r.vote_threshold <= pwdata[7:0];
        REG_INTERVAL:  cfg_r.check_interval <= pwdata[15:0];
        REG_REP_ACKED: cfg_r.repeat_acked   <= pwdata[15:0];
        REG_REP_UNACK: cfg_r.repeat_unacked <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW:    prdata = {24'd0, cfg_r.window_length};
      REG_THRESHOLD: prdata = {24'd0, cfg_r.vote_threshold};
      REG_INTERVAL:  prdata = {16'd0, cfg_r.check_interval};
      REG_REP_ACKED: prdata = {16'd0, cfg_r.repeat_acked};
      REG_REP_UNACK: prdata = {16'd0, cfg_r.repeat_unacked};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/tlam_core.sv */
// Monitor state registers and single-pass next-state / result logic.
`default_nettype none

module tlam_core
  import tlam_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [1:0] in_cmd,
  input  wire logic       in_low_wet,
  input  wire logic       in_high_wet,
  input  wire logic       in_acked,
  input  wire cfg_t       cfg,
  output result_t         res
);

  // compare widths wide enough for both counter and register
  localparam int KW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
  localparam int TW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] low_cnt_r, low_cnt_nxt;
  logic [COUNT_BITS-1:0] high_cnt_r, high_cnt_nxt;
  logic [COUNT_BITS-1:0] samp_cnt_r, samp_cnt_nxt;
  logic [1:0]            last_level_r, last_level_nxt;
  logic                  last_ack_r, last_ack_nxt;
  logic                  err_r, err_nxt;
  logic [TIMER_BITS-1:0] intv_cnt_r, intv_cnt_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;

  logic [1:0]            report;
  logic [1:0]            show;
  logic [1:0]            lvl;
  logic                  lo_trig;
  logic                  hi_trig;
  logic                  win_done;
  logic                  timed_out;
  logic [15:0]           rep_time;
  logic [TIMER_BITS-1:0] intv_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FIRST;
      low_cnt_r    <= '0;
      high_cnt_r   <= '0;
      samp_cnt_r   <= '0;
      last_level_r <= LVL_GOOD;
      last_ack_r   <= 1'b0;
      err_r        <= 1'b0;
      intv_cnt_r   <= '0;
      elapsed_r    <= '0;
    end else if (in_fire) begin
      phase_r      <= phase_nxt;
      low_cnt_r    <= low_cnt_nxt;
      high_cnt_r   <= high_cnt_nxt;
      samp_cnt_r   <= samp_cnt_nxt;
      last_level_r <= last_level_nxt;
      last_ack_r   <= last_ack_nxt;
      err_r        <= err_nxt;
      intv_cnt_r   <= intv_cnt_nxt;
      elapsed_r    <= elapsed_nxt;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    low_cnt_nxt    = low_cnt_r;
    high_cnt_nxt   = high_cnt_r;
    samp_cnt_nxt   = samp_cnt_r;
    last_level_nxt = last_level_r;
    last_ack_nxt   = last_ack_r;
    err_nxt        = err_r;
    intv_cnt_nxt   = intv_cnt_r;
    elapsed_nxt    = elapsed_r;
    report         = REP_NONE;
    show           = SHOW_NONE;
    lvl            = LVL_GOOD;
    lo_trig        = 1'b0;
    hi_trig        = 1'b0;
    win_done       = 1'b0;
    timed_out      = 1'b0;
    rep_time       = last_ack_r ? cfg.repeat_acked : cfg.repeat_unacked;
    intv_inc       = (intv_cnt_r != TMAX) ? intv_cnt_r + 1'b1 : intv_cnt_r;

    case (in_cmd)
      CMD_TICK: begin
        if (phase_r == PH_WAIT || phase_r == PH_CHECK) begin
          if (elapsed_r != TMAX) elapsed_nxt = elapsed_r + 1'b1;
        end
        if (phase_r == PH_WAIT) begin
          intv_cnt_nxt = intv_inc;
          if (TW'(intv_inc) >= TW'(cfg.check_interval)) begin
            phase_nxt    = PH_CHECK;
            low_cnt_nxt  = '0;
            high_cnt_nxt = '0;
            samp_cnt_nxt = '0;
          end
        end
      end
      CMD_SAMPLE: begin
        if (phase_r == PH_FIRST || phase_r == PH_CHECK) begin
          if (in_low_wet && low_cnt_r != CMAX) low_cnt_nxt = low_cnt_r + 1'b1;
          if (in_high_wet && high_cnt_r != CMAX) high_cnt_nxt = high_cnt_r + 1'b1;
          if (samp_cnt_r != CMAX) samp_cnt_nxt = samp_cnt_r + 1'b1;
          win_done = (KW'(samp_cnt_nxt) >= KW'(cfg.window_length)) || (samp_cnt_nxt == CMAX);
          lo_trig  = KW'(low_cnt_nxt) > KW'(cfg.vote_threshold);
          hi_trig  = KW'(high_cnt_nxt) > KW'(cfg.vote_threshold);
          if (lo_trig && !hi_trig)      lvl = LVL_LOW;
          else if (hi_trig && !lo_trig) lvl = LVL_HIGH;
          else                          lvl = LVL_GOOD;
          if (win_done) begin
            if (phase_r == PH_FIRST) begin
              last_level_nxt = lvl;
              if (lvl == LVL_LOW) begin
                show      = SHOW_LOW;
                report    = REP_LOW;
                phase_nxt = PH_RADIO;
              end else if (lvl == LVL_HIGH) begin
                show      = SHOW_HIGH;
                report    = REP_HIGH;
                phase_nxt = PH_RADIO;
              end else begin
                show         = SHOW_GOOD;
                last_ack_nxt = 1'b0;
                phase_nxt    = PH_WAIT;
                intv_cnt_nxt = '0;
                elapsed_nxt  = '0;
              end
            end else begin
              timed_out = (last_level_r != LVL_GOOD) && (TW'(elapsed_r) >= TW'(rep_time));
              if (lvl != last_level_r || timed_out) begin
                phase_nxt    = PH_FIRST;
                low_cnt_nxt  = '0;
                high_cnt_nxt = '0;
                samp_cnt_nxt = '0;
              end else begin
                phase_nxt    = PH_WAIT;
                intv_cnt_nxt = '0;
              end
            end
          end
        end
      end
      CMD_RADIO: begin
        if (phase_r == PH_RADIO) begin
          last_ack_nxt = in_acked;
          err_nxt      = ~in_acked;
          phase_nxt    = PH_WAIT;
          intv_cnt_nxt = '0;
          elapsed_nxt  = '0;
        end
      end
      default: ;  // unknown kind: status only
    endcase

    res.report_request = report;
    res.show_level     = show;
    res.want_samples   = (phase_nxt == PH_FIRST) || (phase_nxt == PH_CHECK);
    res.link_error     = err_nxt;
    res.current_level  = last_level_nxt;
  end

endmodule

`default_nettype wire

/* design/tlam_outbuf.sv */
// Two-entry output buffer: result register plus skid register.
`default_nettype none

module tlam_outbuf
  import tlam_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         push_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;
  logic    pop;

  assign pop        = out_valid_r & out_ready;
  assign push_ready = ~skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

`default_nettype wire

/* design/tank_level_alarm_monitor_top.sv */
// Top level of the tank level alarm monitor: config regs, core and output buffer.
// A result is registered at its input transfer: in the result register, or in the skid register while a result stalls.
// Throughput: one item per cycle while the skid register is free; the core state updates in a single pass per item.
// A two-entry output buffer keeps input ready for one more item while a result stalls.
// Reset (rst_n, synchronous, active low): first sampling window, level good,
// counters and timers cleared, registers at their defaults, output buffer empty.
`default_nettype none

module tank_level_alarm_monitor_top
  import tlam_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,  // vote and sample counter width
  parameter int TIMER_BITS = TIMER_BITS_DEF   // seconds counter width
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input item channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_cmd,
  input  wire logic                 in_low_wet,
  input  wire logic                 in_high_wet,
  input  wire logic                 in_acked,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [1:0]           out_report_request,
  output logic      [1:0]           out_show_level,
  output logic                      out_want_samples,
  output logic                      out_link_error,
  output logic      [1:0]           out_current_level,
  // configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [DATA_BITS-1:0] pwdata,
  output logic      [DATA_BITS-1:0] prdata,
  output logic                      pready
);

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  logic    in_fire;

  // an item transfers whenever it is valid and the skid stage is free
  assign in_fire = in_valid & in_ready;

  tlam_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // state registers update at the transfer; result is computed the same pass
  tlam_core #(
    .COUNT_BITS (COUNT_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_cmd      (in_cmd),
    .in_low_wet  (in_low_wet),
    .in_high_wet (in_high_wet),
    .in_acked    (in_acked),
    .cfg         (cfg),
    .res         (core_res)
  );

  // result register + skid register
  tlam_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_data  (core_res),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_res)
  );

  assign out_report_request = out_res.report_request;
  assign out_show_level     = out_res.show_level;
  assign out_want_samples   = out_res.want_samples;
  assign out_link_error     = out_res.link_error;
  assign out_current_level  = out_res.current_level;

  // a report always leaves the sampling window for the radio wait
  a_report_no_window: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_report_request != REP_NONE) |-> !out_want_samples)
    else $error("report issued while still sampling");

  // a report comes only with a first-window decision shown
  a_report_has_show: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_report_request != REP_NONE) |-> (out_show_level != SHOW_NONE))
    else $error("report without level display");

  // good level is never reported
  a_good_no_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_show_level == SHOW_GOOD) |-> (out_report_request == REP_NONE))
    else $error("good level reported");

  // a high report matches the current level
  a_report_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_report_request == REP_HIGH) |-> (out_current_level == LVL_HIGH))
    else $error("high report with other level");

  // input stalls only while both buffer entries hold results
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

`default_nettype wire
